@@ sv/sfs_pkg.sv @@
// shared constants and codes for the sprite frame sequencer
package sfs_pkg;

    // fixed field widths
    localparam int OP_BITS    = 3;
    localparam int DELTA_BITS = 16;
    localparam int SPEED_BITS = 16;
    localparam int HOLD_BITS  = 16;
    localparam int SLOT_BITS  = 4;
    localparam int CNT_BITS   = 5;
    localparam int IDX_BITS   = 4;
    localparam int ACC_BITS   = 32;

    // configuration port
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // parameter defaults
    localparam int FRAME_DEPTH_DEF = 16;
    localparam int COORD_BITS_DEF  = 12;

    // register reset values
    localparam logic [CNT_BITS-1:0]   FRAME_COUNT_RST = '0;
    localparam logic [SPEED_BITS-1:0] SPEED_RST       = SPEED_BITS'(256);
    localparam logic                  LOOP_RST        = 1'b1;
    localparam logic                  PING_PONG_RST   = 1'b0;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPEED       = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOOP        = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PING_PONG   = 2'd3;

    // word operation codes
    localparam logic [OP_BITS-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PLAY   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_PAUSE  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_RESUME = 3'd4;
    localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd5;

endpackage

@@ sv/sfs_ram.sv @@
// generic single-write, single-read ram with registered read data
module sfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sprite_frame_sequencer.sv @@
// sprite frame sequencer: frame table in ram, timer and frame stepping control
//
// Input channel (i_in_valid / o_in_stall) carries one word per event: a tick with
// its elapsed time, play, stop, pause, resume, or a frame table entry write.
// Every accepted word gives exactly one output word (o_out_valid / i_out_stall)
// holding the current frame rectangle, play-order index, playing flag and a
// one-word ended flag after that event has been applied.
// Registers (frame count, speed, loop, ping-pong) are written through the plain
// write port; the user must do so only while the block is idle (not enforced).
// Each word runs through the states in order: play, stop, pause, resume,
// unknown codes and ticks with nothing to play go from execute to output, a table
// write adds a fetch state, and a playing tick adds the timer add and the frame
// stepping loop, which advances at most FRAME_DEPTH frames. The next word can be
// taken in the cycle after the result is loaded. The stepping loop does one ram
// read per advance, with the next address issued in the same cycle as the hold time compare.
// Reset clears the timer, position, direction and playing flag and sets the registers
// to their defaults; the frame table is not cleared and must be written before use.
// A stalled output keeps its word; the block holds the next result until the
// output register is free and meanwhile accepts no new word.
module sprite_frame_sequencer
    #(
    parameter int FRAME_DEPTH = sfs_pkg::FRAME_DEPTH_DEF,
    parameter int COORD_BITS  = sfs_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [sfs_pkg::CFG_ADDR_BITS-1:0] i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sfs_pkg::OP_BITS-1:0]       i_op,
    input  logic [sfs_pkg::DELTA_BITS-1:0]    i_delta_time,
    input  logic [sfs_pkg::SLOT_BITS-1:0]     i_frame_slot,
    input  logic [COORD_BITS-1:0]             i_rect_x,
    input  logic [COORD_BITS-1:0]             i_rect_y,
    input  logic [COORD_BITS-1:0]             i_rect_w,
    input  logic [COORD_BITS-1:0]             i_rect_h,
    input  logic [sfs_pkg::HOLD_BITS-1:0]     i_hold_time,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [COORD_BITS-1:0]             o_cur_x,
    output logic [COORD_BITS-1:0]             o_cur_y,
    output logic [COORD_BITS-1:0]             o_cur_w,
    output logic [COORD_BITS-1:0]             o_cur_h,
    output logic [sfs_pkg::IDX_BITS-1:0]      o_cur_index,
    output logic                              o_is_playing,
    output logic                              o_ended
);

    import sfs_pkg::*;

    localparam int PW = $clog2(FRAME_DEPTH);
    localparam int IW = $clog2(FRAME_DEPTH + 1);
    localparam int XW = ((PW > CNT_BITS) ? PW : CNT_BITS) + 2;
    localparam int EW = 4 * COORD_BITS + HOLD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_STEP,
        S_FETCH,
        S_OUT
    } t_state;

    t_state                r_state, n_state;

    // latched word
    logic [OP_BITS-1:0]    r_op;
    logic [DELTA_BITS-1:0] r_delta;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [COORD_BITS-1:0] r_x, r_y, r_w, r_h;
    logic [HOLD_BITS-1:0]  r_hold;

    // sequencing state
    logic [ACC_BITS-1:0]   r_prod;
    logic [ACC_BITS-1:0]   r_accum, n_accum;
    logic [PW-1:0]         r_pos, n_pos;
    logic                  r_rev, n_rev;
    logic                  r_run, n_run;
    logic                  r_ended, n_ended;
    logic [IW-1:0]         r_iter, n_iter;

    // configuration registers
    logic [CNT_BITS-1:0]   r_frame_count;
    logic [SPEED_BITS-1:0] r_speed;
    logic                  r_loop;
    logic                  r_pp;

    // output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_cur_w, r_cur_h;
    logic [IDX_BITS-1:0]   r_cur_index;
    logic                  r_is_playing;
    logic                  r_out_ended;

    // ram interface
    logic                  ram_we;
    logic [PW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [PW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;
    logic [HOLD_BITS-1:0]  q_hold;
    logic [ACC_BITS-1:0]   need;

    // derived values
    logic [CNT_BITS-1:0]   act_cnt;
    logic [XW-1:0]         cnt_x;
    logic                  cnt_zero;
    logic [XW-1:0]         rd_pos_x, rd_posc_x, rd_phys_x;
    logic [XW-1:0]         out_posc_x;
    logic [XW-1:0]         inc_x;
    logic [ACC_BITS:0]     sum_wide;
    logic [31:0]           slot_ext;
    logic                  slot_ok;
    logic                  in_take;
    logic                  out_free;

    // active frame count, capped at the table depth
    always_comb begin
        if (32'(r_frame_count) > 32'(FRAME_DEPTH)) begin
            act_cnt = CNT_BITS'(FRAME_DEPTH);
        end else begin
            act_cnt = r_frame_count;
        end
    end

    assign cnt_x    = XW'(act_cnt);
    assign cnt_zero = (act_cnt == '0);

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign slot_ext = 32'(i_frame_slot);
    assign slot_ok  = (32'(r_slot) < 32'(FRAME_DEPTH));

    assign q_hold   = ram_rdata[HOLD_BITS-1:0];
    assign need     = ACC_BITS'({q_hold, 8'h00});
    assign inc_x    = XW'(r_pos) + XW'(1);
    assign sum_wide = {1'b0, r_accum} + {1'b0, r_prod};

    // next state of the sequencer
    always_comb begin
        n_state = r_state;
        n_accum = r_accum;
        n_pos   = r_pos;
        n_rev   = r_rev;
        n_run   = r_run;
        n_ended = r_ended;
        n_iter  = r_iter;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_ended = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                case (r_op)
                    OP_TICK: begin
                        if (r_run && !cnt_zero) begin
                            if (XW'(r_pos) >= cnt_x) begin
                                n_pos = PW'(cnt_x - XW'(1));
                            end
                            n_state = S_ADD;
                        end
                    end
                    OP_PLAY: begin
                        if (!r_run) begin
                            n_run   = 1'b1;
                            n_pos   = '0;
                            n_accum = '0;
                        end
                    end
                    OP_STOP: begin
                        n_run   = 1'b0;
                        n_pos   = '0;
                        n_accum = '0;
                    end
                    OP_PAUSE: begin
                        n_run = 1'b0;
                    end
                    OP_RESUME: begin
                        n_run = 1'b1;
                    end
                    OP_WRITE: begin
                        n_state = S_FETCH;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_ADD: begin
                // saturating timer update
                n_accum = sum_wide[ACC_BITS] ? '1 : sum_wide[ACC_BITS-1:0];
                n_iter  = '0;
                n_state = S_STEP;
            end
            S_STEP: begin
                if ((r_iter == IW'(FRAME_DEPTH)) || (r_accum < need)) begin
                    n_state = S_OUT;
                end else begin
                    n_accum = r_accum - need;
                    n_iter  = r_iter + IW'(1);
                    if (inc_x >= cnt_x) begin
                        if (r_loop) begin
                            if (r_pp) begin
                                n_rev = ~r_rev;
                            end
                            n_pos = '0;
                        end else begin
                            n_pos   = PW'(cnt_x - XW'(1));
                            n_run   = 1'b0;
                            n_ended = 1'b1;
                            n_state = S_OUT;
                        end
                    end else begin
                        n_pos = PW'(inc_x);
                    end
                end
            end
            S_FETCH: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read address follows the next position so its data arrives in the following cycle
    always_comb begin
        rd_pos_x = XW'(n_pos);
        if (rd_pos_x >= cnt_x) begin
            rd_posc_x = cnt_x - XW'(1);
        end else begin
            rd_posc_x = rd_pos_x;
        end
        if (n_rev) begin
            rd_phys_x = cnt_x - XW'(1) - rd_posc_x;
        end else begin
            rd_phys_x = rd_posc_x;
        end
        if (cnt_zero) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = PW'(rd_phys_x);
        end
    end

    // clamped position shown on the output
    always_comb begin
        if (!cnt_zero && (XW'(r_pos) >= cnt_x)) begin
            out_posc_x = cnt_x - XW'(1);
        end else begin
            out_posc_x = XW'(r_pos);
        end
    end

    // table write from the latched word
    assign ram_we    = (r_state == S_EXEC) && (r_op == OP_WRITE) && slot_ok;
    assign ram_waddr = PW'(r_slot);
    assign ram_wdata = {r_x, r_y, r_w, r_h, r_hold};

    sfs_ram #(
        .WIDTH (EW),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // state, sequencing registers, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_accum       <= '0;
            r_pos         <= '0;
            r_rev         <= 1'b0;
            r_run         <= 1'b0;
            r_ended       <= 1'b0;
            r_iter        <= '0;
            r_frame_count <= FRAME_COUNT_RST;
            r_speed       <= SPEED_RST;
            r_loop        <= LOOP_RST;
            r_pp          <= PING_PONG_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_accum <= n_accum;
            r_pos   <= n_pos;
            r_rev   <= n_rev;
            r_run   <= n_run;
            r_ended <= n_ended;
            r_iter  <= n_iter;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_COUNT: r_frame_count <= i_cfg_data[CNT_BITS-1:0];
                    REG_SPEED:       r_speed       <= i_cfg_data[SPEED_BITS-1:0];
                    REG_LOOP:        r_loop        <= i_cfg_data[0];
                    REG_PING_PONG:   r_pp          <= i_cfg_data[0];
                    default:         r_loop        <= r_loop;
                endcase
            end

            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        // word capture
        if (in_take) begin
            r_op    <= i_op;
            r_delta <= i_delta_time;
            r_slot  <= slot_ext[SLOT_BITS-1:0];
            r_x     <= i_rect_x;
            r_y     <= i_rect_y;
            r_w     <= i_rect_w;
            r_h     <= i_rect_h;
            r_hold  <= i_hold_time;
        end

        // scaled elapsed time, registered before the add
        r_prod <= ACC_BITS'(r_delta) * ACC_BITS'(r_speed);

        // output payload
        if ((r_state == S_OUT) && out_free) begin
            if (cnt_zero) begin
                r_cur_x     <= '0;
                r_cur_y     <= '0;
                r_cur_w     <= '0;
                r_cur_h     <= '0;
                r_cur_index <= '0;
            end else begin
                r_cur_x     <= ram_rdata[HOLD_BITS + 3*COORD_BITS +: COORD_BITS];
                r_cur_y     <= ram_rdata[HOLD_BITS + 2*COORD_BITS +: COORD_BITS];
                r_cur_w     <= ram_rdata[HOLD_BITS + COORD_BITS +: COORD_BITS];
                r_cur_h     <= ram_rdata[HOLD_BITS +: COORD_BITS];
                r_cur_index <= out_posc_x[IDX_BITS-1:0];
            end
            r_is_playing <= r_run;
            r_out_ended  <= r_ended;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cur_x      = r_cur_x;
    assign o_cur_y      = r_cur_y;
    assign o_cur_w      = r_cur_w;
    assign o_cur_h      = r_cur_h;
    assign o_cur_index  = r_cur_index;
    assign o_is_playing = r_is_playing;
    assign o_ended      = r_out_ended;

    // a word taken closes the input until its result is loaded
    a_take_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input still open after a word was taken");

    // stepping never leaves the position outside the active frames
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP) && !cnt_zero) |-> (XW'(r_pos) < cnt_x))
        else $error("position outside active frames while stepping");

    // an ended word always reports the animation stopped
    a_ended_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ended) |-> !o_is_playing)
        else $error("ended flag with animation still playing");

    // only a tick can end the animation
    a_ended_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ended && (r_state != S_IDLE)) |-> (r_op == OP_TICK))
        else $error("ended raised by a word other than a tick");

    // table writes come only from a write word in its execute cycle
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_op == OP_WRITE) && $past(r_state == S_IDLE)))
        else $error("frame table written outside a write word");

endmodule
